### src/gcr_pkg.sv
// Shared types and constants of the GPIO controller register block.
package gcr_pkg;

  // Result fields travel at fixed widths whatever the pin count.
  localparam int FIELD_W       = 54;
  localparam int WORD_W        = 32;
  localparam int IDX_W         = 6;
  localparam int SEL_W         = 3;
  localparam int PINS_PER_WORD = 10;
  localparam int FSEL_WORDS    = 6;
  localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);

  localparam logic [SEL_W-1:0] SEL_OUTPUT = 3'd1;

  // Register word indices (byte offset / 4).
  localparam logic [IDX_W-1:0] W_FSEL = IDX_W'(8'h00 / 4);
  localparam logic [IDX_W-1:0] W_SET  = IDX_W'(8'h1C / 4);
  localparam logic [IDX_W-1:0] W_CLR  = IDX_W'(8'h28 / 4);
  localparam logic [IDX_W-1:0] W_LEV  = IDX_W'(8'h34 / 4);
  localparam logic [IDX_W-1:0] W_EDS  = IDX_W'(8'h40 / 4);
  localparam logic [IDX_W-1:0] W_REN  = IDX_W'(8'h4C / 4);
  localparam logic [IDX_W-1:0] W_FEN  = IDX_W'(8'h58 / 4);
  localparam logic [IDX_W-1:0] W_HEN  = IDX_W'(8'h64 / 4);
  localparam logic [IDX_W-1:0] W_LEN  = IDX_W'(8'h70 / 4);
  localparam logic [IDX_W-1:0] W_AREN = IDX_W'(8'h7C / 4);
  localparam logic [IDX_W-1:0] W_AFEN = IDX_W'(8'h88 / 4);
  localparam logic [IDX_W-1:0] W_FSEL_LAST = W_FSEL + IDX_W'(FSEL_WORDS - 1);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  // Stream packing.
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 144;

  localparam int IN_IDX_LO  = 0;
  localparam int IN_WDAT_LO = IN_IDX_LO + IDX_W;
  localparam int IN_PINS_LO = IN_WDAT_LO + WORD_W;

  localparam int OUT_RDAT_LO = 0;
  localparam int OUT_LVL_LO  = OUT_RDAT_LO + WORD_W;
  localparam int OUT_OE_LO   = OUT_LVL_LO + FIELD_W;
  localparam int OUT_EP_BIT  = OUT_OE_LO + FIELD_W;
  localparam int OUT_USED_W  = OUT_EP_BIT + 1;

endpackage

### src/gpio_controller_registers.sv
// GPIO controller register block: register map, output latch and event detect.
//
//  channel | dir | tdata fields (low bit up)                        | tuser
//  --------+-----+--------------------------------------------------+---------
//  s_axis  | in  | reg_index[5:0] write_data[37:6] pin_levels[91:38]| req_type
//  m_axis  | out | read_data[31:0] out_levels[85:32]                | -
//          |     | out_enable[139:86] event_pending[140]            |
//
// One request is taken every cycle while not stalled: decode, state update and
// result build sit between the state registers and a single result register.
// Each request yields one registered result, valid in the cycle after it is accepted.
// s_axis_tready_o is high while the result register is empty or being drained,
// so a stalled master side leaves one result waiting and holds s_axis off.
// rst_ni clears all pin state (function selects to input) and the result valid.
module gpio_controller_registers
  import gcr_pkg::*;
#(
  parameter int NUM_PINS = 54
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // reg_index, write_data, pin_levels, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // read_data, out_levels, out_enable, event_pending, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  typedef logic [FSEL_WORDS-1:0][PINS_PER_WORD-1:0][SEL_W-1:0] fsel_t;
  typedef logic [NUM_PINS-1:0] pins_t;

  // ---------------------------------------------------------------------------
  // Bank helpers: word 0 covers pins 0..31, word 1 pins 32..NUM_PINS-1.
  // ---------------------------------------------------------------------------
  function automatic pins_t spread(input logic hi, input logic [WORD_W-1:0] w);
    logic [63:0] s;
    s = hi ? {w, 32'b0} : {32'b0, w};
    return s[NUM_PINS-1:0];
  endfunction

  function automatic pins_t put(input pins_t v, input logic hi,
                                input logic [WORD_W-1:0] w);
    return (v & ~spread(hi, '1)) | spread(hi, w);
  endfunction

  function automatic logic [WORD_W-1:0] bank_get(input pins_t v, input logic hi);
    logic [63:0] v64;
    v64 = 64'(v);
    return hi ? v64[63:32] : v64[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsel_t fsel_q, fsel_d;
  pins_t latch_q, latch_d;
  pins_t eds_q, eds_d;
  pins_t ren_q, ren_d;
  pins_t fen_q, fen_d;
  pins_t hen_q, hen_d;
  pins_t len_q, len_d;
  pins_t aren_q, aren_d;
  pins_t afen_q, afen_d;
  pins_t prev_q, prev_d;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Request fields
  logic                    s_acc;
  logic [IDX_W-1:0]        idx;
  logic [WORD_W-1:0]       wdata;
  pins_t                   cur;
  logic [WORD_W-1:0]       rdata;
  logic [63:0]             oe64;
  logic [63:0]             lvl64;
  pins_t                   rise;
  pins_t                   fall;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign idx   = s_axis_tdata_i[IN_IDX_LO +: IDX_W];
  assign wdata = s_axis_tdata_i[IN_WDAT_LO +: WORD_W];
  assign cur   = NUM_PINS'(64'(s_axis_tdata_i[IN_PINS_LO +: FIELD_W]));

  assign rise = cur & ~prev_q;
  assign fall = prev_q & ~cur;

  // ---------------------------------------------------------------------------
  // Decode and next state
  // ---------------------------------------------------------------------------
  always_comb begin
    fsel_d  = fsel_q;
    latch_d = latch_q;
    eds_d   = eds_q;
    ren_d   = ren_q;
    fen_d   = fen_q;
    hen_d   = hen_q;
    len_d   = len_q;
    aren_d  = aren_q;
    afen_d  = afen_q;
    prev_d  = prev_q;
    rdata   = '0;

    unique case (req_e'(s_axis_tuser_i))
      REQ_TICK: begin
        eds_d  = eds_q | ((ren_q | aren_q) & rise) | ((fen_q | afen_q) & fall)
               | (hen_q & cur) | (len_q & ~cur);
        prev_d = cur;
      end
      REQ_READ: begin
        unique case (idx) inside
          [W_FSEL:W_FSEL_LAST]:  rdata = WORD_W'(fsel_q[idx[FSEL_IDX_W-1:0]]);
          W_LEV,  W_LEV  + 1'b1: rdata = bank_get(prev_q, idx != W_LEV);
          W_EDS,  W_EDS  + 1'b1: rdata = bank_get(eds_q,  idx != W_EDS);
          W_REN,  W_REN  + 1'b1: rdata = bank_get(ren_q,  idx != W_REN);
          W_FEN,  W_FEN  + 1'b1: rdata = bank_get(fen_q,  idx != W_FEN);
          W_HEN,  W_HEN  + 1'b1: rdata = bank_get(hen_q,  idx != W_HEN);
          W_LEN,  W_LEN  + 1'b1: rdata = bank_get(len_q,  idx != W_LEN);
          W_AREN, W_AREN + 1'b1: rdata = bank_get(aren_q, idx != W_AREN);
          W_AFEN, W_AFEN + 1'b1: rdata = bank_get(afen_q, idx != W_AFEN);
          default:               rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (idx) inside
          [W_FSEL:W_FSEL_LAST]: begin
            // Pins past the pin count keep their reset value (input).
            for (int w = 0; w < FSEL_WORDS; w++) begin
              for (int k = 0; k < PINS_PER_WORD; k++) begin
                if ((w * PINS_PER_WORD + k < NUM_PINS) &&
                    (idx[FSEL_IDX_W-1:0] == FSEL_IDX_W'(w))) begin
                  fsel_d[w][k] = wdata[k*SEL_W +: SEL_W];
                end
              end
            end
          end
          W_SET,  W_SET  + 1'b1: latch_d = latch_q | spread(idx != W_SET, wdata);
          W_CLR,  W_CLR  + 1'b1: latch_d = latch_q & ~spread(idx != W_CLR, wdata);
          W_EDS,  W_EDS  + 1'b1: eds_d   = eds_q & ~spread(idx != W_EDS, wdata);
          W_REN,  W_REN  + 1'b1: ren_d   = put(ren_q,  idx != W_REN,  wdata);
          W_FEN,  W_FEN  + 1'b1: fen_d   = put(fen_q,  idx != W_FEN,  wdata);
          W_HEN,  W_HEN  + 1'b1: hen_d   = put(hen_q,  idx != W_HEN,  wdata);
          W_LEN,  W_LEN  + 1'b1: len_d   = put(len_q,  idx != W_LEN,  wdata);
          W_AREN, W_AREN + 1'b1: aren_d  = put(aren_q, idx != W_AREN, wdata);
          W_AFEN, W_AFEN + 1'b1: afen_d  = put(afen_q, idx != W_AFEN, wdata);
          default: ;  // level, pull control, gaps: ignored
        endcase
      end
      default: ;  // unknown request type: no effect, read_data zero
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result build: reflects the state after this request
  // ---------------------------------------------------------------------------
  always_comb begin
    oe64 = '0;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      for (int k = 0; k < PINS_PER_WORD; k++) begin
        if (w * PINS_PER_WORD + k < NUM_PINS) begin
          oe64[w * PINS_PER_WORD + k] = (fsel_d[w][k] == SEL_OUTPUT);
        end
      end
    end
  end

  assign lvl64 = 64'(latch_d);

  always_comb begin
    out_data_d                           = '0;
    out_data_d[OUT_RDAT_LO +: WORD_W]    = rdata;
    out_data_d[OUT_LVL_LO  +: FIELD_W]   = lvl64[FIELD_W-1:0];
    out_data_d[OUT_OE_LO   +: FIELD_W]   = oe64[FIELD_W-1:0];
    out_data_d[OUT_EP_BIT]               = |eds_d;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= '0;
      latch_q <= '0;
      eds_q   <= '0;
      ren_q   <= '0;
      fen_q   <= '0;
      hen_q   <= '0;
      len_q   <= '0;
      aren_q  <= '0;
      afen_q  <= '0;
      prev_q  <= '0;
    end else if (s_acc) begin
      fsel_q  <= fsel_d;
      latch_q <= latch_d;
      eds_q   <= eds_d;
      ren_q   <= ren_d;
      fen_q   <= fen_d;
      hen_q   <= hen_d;
      len_q   <= len_d;
      aren_q  <= aren_d;
      afen_q  <= afen_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> out_valid_q)
    else $error("accepted request produced no result");

  a_pending_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (out_data_q[OUT_EP_BIT] == (|eds_q)))
    else $error("event_pending disagrees with event status");

  a_levels_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (out_data_q[OUT_LVL_LO +: FIELD_W] == FIELD_W'(64'(latch_q))))
    else $error("out_levels disagrees with output latch");

  a_read_no_side_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser_i == REQ_READ)) |=>
      ($stable(latch_q) && $stable(eds_q) && $stable(fsel_q) && $stable(prev_q)))
    else $error("register read changed state");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[OUT_TDATA_W-1:OUT_USED_W] == '0))
    else $error("result pad bits not zero");

endmodule
